// ===== design/tod_pkg.sv =====
`timescale 1ns / 1ps

package tod_pkg;

    localparam int unsigned TPS_RESET   = 20;
    localparam int unsigned SEC_MOD     = 60;
    localparam int unsigned MIN_MOD     = 60;
    localparam int unsigned HOUR_MOD    = 24;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_CR    = 8'h0d;
    localparam logic [7:0] ASCII_COLON = 8'h3a;
    localparam logic [3:0] ASCII_DIGIT = 4'h3;

    // One snapshot of the time of day, taken at a second boundary.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } time_t;

    // Two decimal digits of a value below 64, tens in the upper nibble.
    // The quotient by ten is a multiply by 205 and a shift by 11, which is
    // exact for every value in range.
    function automatic logic [7:0] split_digits(input logic [5:0] v);
        logic [13:0] prod;
        logic [2:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        begin
            prod     = {8'd0, v} * 14'd205;
            tens     = prod[13:11];
            tens_x10 = {4'd0, tens} * 7'd10;
            units    = {1'b0, v} - tens_x10;
            split_digits = {1'b0, tens, units[3:0]};
        end
    endfunction

endpackage

// ===== design/tod_front.sv =====
`timescale 1ns / 1ps

module tod_front
    import tod_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_valid,
    output logic        tick_ready,
    input  logic        tick,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        push,
    output time_t       push_data,
    input  logic        queue_full
);

    logic [7:0] tps_reg;
    logic [7:0] tick_count_reg;
    logic [7:0] tick_count_next;
    time_t      time_reg;
    time_t      time_next;
    logic [8:0] count_inc;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic       accept;
    logic       boundary;

    assign cfg_ready  = 1'b1;
    assign tick_ready = !queue_full;
    assign accept     = tick_valid && tick_ready && tick;

    assign count_inc = {1'b0, tick_count_reg} + 9'd1;
    assign boundary  = count_inc >= {1'b0, tps_reg};
    assign sec_inc   = {1'b0, time_reg.seconds} + 7'd1;
    assign min_inc   = {1'b0, time_reg.minutes} + 7'd1;
    assign hour_inc  = {1'b0, time_reg.hours} + 6'd1;

    always_comb
    begin
        tick_count_next = boundary ? 8'd0 : count_inc[7:0];
        time_next       = time_reg;
        if (sec_inc >= 7'(SEC_MOD))
        begin
            time_next.seconds = '0;
            if (min_inc >= 7'(MIN_MOD))
            begin
                time_next.minutes = '0;
                time_next.hours   = (hour_inc >= 6'(HOUR_MOD)) ? 5'd0 : hour_inc[4:0];
            end
            else
            begin
                time_next.minutes = min_inc[5:0];
            end
        end
        else
        begin
            time_next.seconds = sec_inc[5:0];
        end
    end

    assign push      = accept && boundary;
    assign push_data = time_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg        <= 8'(TPS_RESET);
            tick_count_reg <= '0;
            time_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tps_reg <= cfg_data;
            end
            if (accept)
            begin
                tick_count_reg <= tick_count_next;
                if (boundary)
                begin
                    time_reg <= time_next;
                end
            end
        end
    end

endmodule

// ===== design/tod_fifo.sv =====
`timescale 1ns / 1ps

module tod_fifo
    import tod_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  time_t push_data,
    output logic  full,
    input  logic  pop,
    output time_t pop_data,
    output logic  not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    time_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/tod_back.sv =====
`timescale 1ns / 1ps

module tod_back
    import tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       queue_valid,
    input  time_t      queue_data,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out,
    output logic       last
);

    localparam logic [3:0] POS_CR       = 4'd0;
    localparam logic [3:0] POS_HOUR_T   = 4'd1;
    localparam logic [3:0] POS_HOUR_U   = 4'd2;
    localparam logic [3:0] POS_COLON_HM = 4'd3;
    localparam logic [3:0] POS_MIN_T    = 4'd4;
    localparam logic [3:0] POS_MIN_U    = 4'd5;
    localparam logic [3:0] POS_COLON_MS = 4'd6;
    localparam logic [3:0] POS_SEC_T    = 4'd7;
    localparam logic [3:0] POS_SEC_U    = 4'd8;

    logic       busy_reg;
    logic [3:0] pos_reg;
    logic [7:0] hour_dig_reg;
    logic [7:0] min_dig_reg;
    logic [7:0] sec_dig_reg;
    logic       out_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       advance;
    logic       line_done;
    logic       load;
    logic [7:0] byte_next;

    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign line_done = advance && (pos_reg == POS_SEC_U);
    assign load      = queue_valid && (!busy_reg || line_done);
    assign pop       = load;

    always_comb
    begin
        unique case (pos_reg)
            POS_CR:       byte_next = ASCII_CR;
            POS_HOUR_T:   byte_next = {ASCII_DIGIT, hour_dig_reg[7:4]};
            POS_HOUR_U:   byte_next = {ASCII_DIGIT, hour_dig_reg[3:0]};
            POS_COLON_HM: byte_next = ASCII_COLON;
            POS_MIN_T:    byte_next = {ASCII_DIGIT, min_dig_reg[7:4]};
            POS_MIN_U:    byte_next = {ASCII_DIGIT, min_dig_reg[3:0]};
            POS_COLON_MS: byte_next = ASCII_COLON;
            POS_SEC_T:    byte_next = {ASCII_DIGIT, sec_dig_reg[7:4]};
            POS_SEC_U:    byte_next = {ASCII_DIGIT, sec_dig_reg[3:0]};
            default:      byte_next = ASCII_CR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hour_dig_reg <= split_digits({1'b0, queue_data.hours});
            min_dig_reg  <= split_digits(queue_data.minutes);
            sec_dig_reg  <= split_digits(queue_data.seconds);
        end
        if (advance)
        begin
            char_reg <= byte_next;
            last_reg <= pos_reg == POS_SEC_U;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_CR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= POS_CR;
            end
            else if (line_done)
            begin
                busy_reg <= 1'b0;
                pos_reg  <= POS_CR;
            end
            else if (advance)
            begin
                pos_reg <= pos_reg + 4'd1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

// ===== design/time_of_day_clock_ascii.sv =====
`timescale 1ns / 1ps

// Time-of-day clock with an ASCII time line. Every accepted transaction on
// the tick channel with tick set is one timer period; a prescaler counts
// these up to ticks_per_second (20 after reset, written through the cfg
// channel, where a value of zero or one makes every tick a second). At each
// second the seconds, minutes and hours advance with wraps at 60, 60 and 24,
// and the block sends nine bytes on the output channel: a carriage return,
// then HH:MM:SS in decimal, with last set on the ninth byte. A tick with the
// tick field clear changes nothing. Ticks that do not end a second are taken
// one per cycle while the queue is not full. A second boundary places a time
// snapshot in a queue of QUEUE_DEPTH lines; the serializer behind it sends
// one byte per cycle while the output channel is ready, and lines follow each
// other without a gap. The tick channel drops ready only while the queue is
// full, which happens when seconds arrive faster than lines go out or the
// output channel stalls.
module time_of_day_clock_ascii
    import tod_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_ready,
    input  logic       tick,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out,
    output logic       last
);

    // Snapshot handoff between the counting front end and the serializer.
    logic  push;
    time_t push_data;
    logic  queue_full;
    logic  pop;
    time_t pop_data;
    logic  queue_valid;

    // The front end keeps the configuration register, the prescaler and
    // the time counters, and produces one snapshot per second.
    tod_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // The queue lets counting continue while a line is still going out.
    tod_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (queue_valid)
    );

    // The serializer turns each snapshot into digits and sends the line
    // through its output register.
    tod_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_valid (queue_valid),
        .queue_data  (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .last        (last)
    );

endmodule

// ===== design/tod_checker.sv =====
`timescale 1ns / 1ps

module tod_checker
    import tod_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_out,
    input logic       last
);

    localparam logic [3:0] POS_FIRST    = 4'd0;
    localparam logic [3:0] POS_COLON_HM = 4'd3;
    localparam logic [3:0] POS_COLON_MS = 4'd6;
    localparam logic [3:0] POS_FINAL    = 4'd8;

    // Place of the next output byte within its line.
    logic [3:0] pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FIRST;
        end
        else if (out_valid && out_ready)
        begin
            pos_reg <= (pos_reg == POS_FINAL) ? POS_FIRST : pos_reg + 4'd1;
        end
    end

    // A stalled byte holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last))
        else $error("output byte changed while stalled");

    // Every line opens with a carriage return.
    a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pos_reg == POS_FIRST |-> char_out == ASCII_CR)
        else $error("line does not start with a carriage return");

    // The flag marks exactly the ninth byte.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last == (pos_reg == POS_FINAL))
        else $error("last flag out of place");

    // Separators stand between the fields.
    a_colons: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pos_reg == POS_COLON_HM || pos_reg == POS_COLON_MS)
        |-> char_out == ASCII_COLON)
        else $error("missing colon");

endmodule

bind time_of_day_clock_ascii tod_checker u_tod_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_out  (char_out),
    .last      (last)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

import tod_pkg::*;

// Keeps its own time of day and tick prescaler, and queues the ASCII bytes
// every accepted tick is due to produce, each packed as {last, char}.
class clock_line_board;
    logic [7:0] tps;
    logic [7:0] tick_count;
    logic [5:0] secs;
    logic [5:0] mins;
    logic [4:0] hrs;
    logic [8:0] bytes_due[$];
    int         mismatches;

    function new();
        tps        = 8'(TPS_RESET);
        tick_count = '0;
        secs       = '0;
        mins       = '0;
        hrs        = '0;
        mismatches = 0;
    endfunction

    function int pending();
        return bytes_due.size();
    endfunction

    function void queue_pair(input int v);
        bytes_due.push_back({1'b0, ASCII_DIGIT, 4'(v / 10)});
        bytes_due.push_back({1'b0, ASCII_DIGIT, 4'(v % 10)});
    endfunction

    function void note_tick(input logic t);
        int nxt;
        if (!t)
            return;
        nxt = tick_count + 1;
        if (nxt < tps)
        begin
            tick_count = nxt[7:0];
            return;
        end
        tick_count = '0;
        if (secs + 1 >= SEC_MOD)
        begin
            secs = '0;
            if (mins + 1 >= MIN_MOD)
            begin
                mins = '0;
                hrs  = (hrs + 1 >= HOUR_MOD) ? 5'd0 : hrs + 5'd1;
            end
            else
                mins = mins + 6'd1;
        end
        else
            secs = secs + 6'd1;
        bytes_due.push_back({1'b0, ASCII_CR});
        queue_pair(int'(hrs));
        bytes_due.push_back({1'b0, ASCII_COLON});
        queue_pair(int'(mins));
        bytes_due.push_back({1'b0, ASCII_COLON});
        queue_pair(int'(secs));
        bytes_due[bytes_due.size() - 1][8] = 1'b1;
    endfunction

    function void check_char(input logic [7:0] ch, input logic lst);
        logic [8:0] want;
        if (bytes_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected line byte: char %h last %b", ch, lst);
            return;
        end
        want = bytes_due.pop_front();
        if (want !== {lst, ch})
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Line byte mismatch: expected char %h last %b, got char %h last %b",
                         want[7:0], want[8], ch, lst);
        end
    endfunction
endclass

module tb;

    // Cycles to let pass after the last expected byte, so that ticks that
    // end no second have surely been counted before the period changes.
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 200000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       tick_valid = 1'b0;
    logic       tick_ready;
    logic       tick       = 1'b0;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data   = 8'd0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] char_out;
    logic       last;

    // Idle rates in percent for the tick sender and the byte receiver.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles      = 0;

    clock_line_board board;

    time_of_day_clock_ascii u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_out   (char_out),
        .last       (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The receiver decides afresh every cycle whether it will take a byte,
    // so stalls land on every position within a time line.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // Every byte transaction on the output channel is checked against the
    // oldest byte still due. Values seen here are those from before the edge.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_char(char_out, last);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one tick transaction and returns at the edge that accepts it,
    // with tick_valid still high. The next call either keeps it high for a
    // back-to-back tick or lowers it for an idle gap, so the valid line never
    // gets two assignments in one time step.
    task automatic send_tick(input logic t);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        board.note_tick(t);
    endtask

    // Stops offering ticks and waits until every due byte has come out,
    // then gives the prescaler time to absorb any tick that ended no second.
    task automatic settle();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Writes ticks_per_second. Only called while the block is idle.
    task automatic write_tps(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.tps = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int phase;

        board = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. With the reset period of 20, ticks with
        // the field clear must change nothing, and three real ticks only
        // advance the prescaler.
        send_tick(1'b0);
        send_tick(1'b0);
        repeat (3)
            send_tick(1'b1);
        settle();

        // The period drops below the current count, so the very next tick
        // ends a second and the count restarts from zero.
        write_tps(8'd2);
        repeat (3)
            send_tick(1'b1);
        settle();

        // A period of zero and a period of one both make every tick a second.
        write_tps(8'd0);
        repeat (3)
            send_tick(1'b1);
        settle();
        write_tps(8'd1);
        send_tick(1'b0);
        repeat (2)
            send_tick(1'b1);
        settle();

        // Largest period: two ticks leave the prescaler part way, and the
        // next phase lowers the period to three or less.
        write_tps(8'd255);
        repeat (2)
            send_tick(1'b1);
        settle();

        // Random part in three phases: sender idles less than the receiver,
        // then the other way round, then no idling at all. Short periods
        // keep time lines frequent; about one tick in ten has the field clear.
        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 75 : 0;
            rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 33 : 0;
            write_tps(8'($urandom_range(3)));
            repeat (28)
                send_tick($urandom_range(9) != 0);
            settle();
        end

        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tod_pkg.sv
design/tod_front.sv
design/tod_fifo.sv
design/tod_back.sv
design/time_of_day_clock_ascii.sv
design/tod_checker.sv
dv/tb.sv
